// ===== rtl/core/bchr_pkg.sv =====
// ----------------------------------------------------------------------------
// bchr_pkg: shared types and constants for the button click/hold/repeat block
// Beat payloads, event codes, register indexes and the register file view.
// ----------------------------------------------------------------------------
package bchr_pkg;

  localparam int NumButtons = 4;
  localparam int CountWidth = 16;
  localparam int NumFields  = 4;
  localparam int RegWidth   = 16;
  localparam int CfgIdxW    = 3;

  localparam int BtnEnter = 0;
  localparam int BtnUp    = 1;
  localparam int BtnDown  = 2;
  localparam int BtnExit  = 3;

  localparam logic [RegWidth-1:0] DebounceReset = 16'd20;
  localparam logic [RegWidth-1:0] HoldReset     = 16'd1000;
  localparam logic [RegWidth-1:0] RepeatReset   = 16'd200;

  typedef enum logic [1:0] {
    EvNone       = 2'd0,
    EvClick      = 2'd1,
    EvHoldOnce   = 2'd2,
    EvHoldRepeat = 2'd3
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce  = 3'd0,
    CfgHoldEnter = 3'd1,
    CfgHoldUp    = 3'd2,
    CfgHoldDown  = 3'd3,
    CfgHoldExit  = 3'd4,
    CfgRepeat    = 3'd5,
    CfgPressed   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic raw_enter;
    logic raw_up;
    logic raw_down;
    logic raw_exit;
  } in_t;

  typedef struct packed {
    logic [1:0] event_enter;
    logic [1:0] event_up;
    logic [1:0] event_down;
    logic [1:0] event_exit;
  } out_t;

  typedef struct packed {
    logic [RegWidth-1:0]                debounce_ticks;
    logic [NumFields-1:0][RegWidth-1:0] hold_ticks;
    logic [RegWidth-1:0]                repeat_ticks;
    logic                               pressed_level;
  } cfg_t;

endpackage

// ===== rtl/core/bchr_cfg.sv =====
// ----------------------------------------------------------------------------
// bchr_cfg: configuration register file
// Holds debounce, hold and repeat thresholds and the pressed pin level.
// ----------------------------------------------------------------------------
module bchr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bchr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bchr_pkg::RegWidth-1:0] cfg_data_i,
  output bchr_pkg::cfg_t                cfg_o
);

  bchr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bchr_pkg::CfgDebounce:  cfg_d.debounce_ticks                  = cfg_data_i;
        bchr_pkg::CfgHoldEnter: cfg_d.hold_ticks[bchr_pkg::BtnEnter] = cfg_data_i;
        bchr_pkg::CfgHoldUp:    cfg_d.hold_ticks[bchr_pkg::BtnUp]    = cfg_data_i;
        bchr_pkg::CfgHoldDown:  cfg_d.hold_ticks[bchr_pkg::BtnDown]  = cfg_data_i;
        bchr_pkg::CfgHoldExit:  cfg_d.hold_ticks[bchr_pkg::BtnExit]  = cfg_data_i;
        bchr_pkg::CfgRepeat:    cfg_d.repeat_ticks                    = cfg_data_i;
        bchr_pkg::CfgPressed:   cfg_d.pressed_level                   = cfg_data_i[0];
        default:                cfg_d                                 = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= bchr_pkg::DebounceReset;
      for (int i = 0; i < bchr_pkg::NumFields; i++) begin
        cfg_q.hold_ticks[i] <= bchr_pkg::HoldReset;
      end
      cfg_q.repeat_ticks  <= bchr_pkg::RepeatReset;
      cfg_q.pressed_level <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/bchr_lane.sv =====
// ----------------------------------------------------------------------------
// bchr_lane: one button's debounce and click/hold/repeat tracker
// Debounces the raw level and runs the hold and repeat timer per tick.
// ----------------------------------------------------------------------------
module bchr_lane #(
  parameter int COUNT_WIDTH = bchr_pkg::CountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          raw_i,
  input  logic                          pressed_level_i,
  input  logic [bchr_pkg::RegWidth-1:0] debounce_ticks_i,
  input  logic [bchr_pkg::RegWidth-1:0] hold_ticks_i,
  input  logic [bchr_pkg::RegWidth-1:0] repeat_ticks_i,
  output bchr_pkg::event_e              event_o
);

  localparam int CmpW = (COUNT_WIDTH > bchr_pkg::RegWidth) ? COUNT_WIDTH
                                                           : bchr_pkg::RegWidth;

  logic                   stable_q, stable_d;
  logic                   fired_q, fired_d;
  logic [COUNT_WIDTH-1:0] deb_q, deb_d, deb_inc;
  logic [COUNT_WIDTH-1:0] hold_q, hold_d, hold_inc;
  logic                   raw_pressed;
  logic                   changed;
  bchr_pkg::event_e       ev;

  assign raw_pressed = (raw_i == pressed_level_i);
  assign deb_inc     = (deb_q == '1) ? deb_q : deb_q + COUNT_WIDTH'(1);
  assign hold_inc    = (hold_q == '1) ? hold_q : hold_q + COUNT_WIDTH'(1);
  assign event_o     = ev;

  always_comb begin
    stable_d = stable_q;
    fired_d  = fired_q;
    deb_d    = deb_q;
    hold_d   = hold_q;
    changed  = 1'b0;
    ev       = bchr_pkg::EvNone;
    if (raw_pressed == stable_q) begin
      deb_d = '0;
    end else begin
      deb_d = deb_inc;
      if (CmpW'(deb_inc) >= CmpW'(debounce_ticks_i)) begin
        changed  = 1'b1;
        deb_d    = '0;
        stable_d = raw_pressed;
        hold_d   = '0;
        fired_d  = 1'b0;
        if (!raw_pressed && !fired_q) begin
          ev = bchr_pkg::EvClick;
        end
      end
    end
    if (!changed && stable_q) begin
      hold_d = hold_inc;
      if (!fired_q) begin
        if (CmpW'(hold_inc) >= CmpW'(hold_ticks_i)) begin
          ev      = bchr_pkg::EvHoldOnce;
          fired_d = 1'b1;
          hold_d  = '0;
        end
      end else if (CmpW'(hold_inc) >= CmpW'(repeat_ticks_i)) begin
        ev     = bchr_pkg::EvHoldRepeat;
        hold_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      fired_q  <= 1'b0;
      deb_q    <= '0;
      hold_q   <= '0;
    end else if (step_i) begin
      stable_q <= stable_d;
      fired_q  <= fired_d;
      deb_q    <= deb_d;
      hold_q   <= hold_d;
    end
  end

  a_fired_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fired_q |-> stable_q)
    else $error("hold marked fired while button released");

  a_repeat_after_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ev == bchr_pkg::EvHoldRepeat) |-> fired_q)
    else $error("repeat event before first hold event");

  a_click_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ev == bchr_pkg::EvClick) |=> !stable_q && !fired_q && (hold_q == '0))
    else $error("click without clean release state");

endmodule

// ===== rtl/core/bchr_merge.sv =====
// ----------------------------------------------------------------------------
// bchr_merge: lane merge and output register
// Packs the lane events into one result beat and holds it until taken.
// ----------------------------------------------------------------------------
module bchr_merge #(
  parameter int LANES = bchr_pkg::NumFields
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  bchr_pkg::event_e lane_ev_i [LANES],
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bchr_pkg::out_t   out_data_o
);

  logic [1:0]     ev_vec [bchr_pkg::NumFields];
  bchr_pkg::out_t data_q, data_d;
  logic           valid_q, valid_d;

  always_comb begin
    for (int i = 0; i < bchr_pkg::NumFields; i++) begin
      ev_vec[i] = (i < LANES) ? lane_ev_i[i] : bchr_pkg::EvNone;
    end
    data_d.event_enter = ev_vec[bchr_pkg::BtnEnter];
    data_d.event_up    = ev_vec[bchr_pkg::BtnUp];
    data_d.event_down  = ev_vec[bchr_pkg::BtnDown];
    data_d.event_exit  = ev_vec[bchr_pkg::BtnExit];
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign valid_d     = step_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/core/button_click_hold_repeat.sv =====
// Output: a result beat is registered and appears in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle; every button lane updates in parallel
// and the output register takes a new beat whenever it is empty or drained.
// Reset: the configuration and lane registers return to their defaults, all buttons
// read released with counters cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// button_click_hold_repeat: debounced click, hold and auto-repeat detector
// Per-button lanes track debounce and hold timers; a merge stage packs events.
// ----------------------------------------------------------------------------
module button_click_hold_repeat #(
  parameter int NUM_BUTTONS = bchr_pkg::NumButtons,
  parameter int COUNT_WIDTH = bchr_pkg::CountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bchr_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bchr_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bchr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bchr_pkg::RegWidth-1:0] cfg_data_i
);

  localparam int Lanes = (NUM_BUTTONS < bchr_pkg::NumFields) ? NUM_BUTTONS
                                                             : bchr_pkg::NumFields;

  bchr_pkg::cfg_t   cfg;
  bchr_pkg::event_e lane_ev [Lanes];
  logic             raw_vec [bchr_pkg::NumFields];
  logic             step;

  assign step = in_valid_i && in_ready_o;

  assign raw_vec[bchr_pkg::BtnEnter] = in_data_i.raw_enter;
  assign raw_vec[bchr_pkg::BtnUp]    = in_data_i.raw_up;
  assign raw_vec[bchr_pkg::BtnDown]  = in_data_i.raw_down;
  assign raw_vec[bchr_pkg::BtnExit]  = in_data_i.raw_exit;

  bchr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  for (genvar b = 0; b < Lanes; b++) begin : g_lane
    bchr_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .step_i           (step),
      .raw_i            (raw_vec[b]),
      .pressed_level_i  (cfg.pressed_level),
      .debounce_ticks_i (cfg.debounce_ticks),
      .hold_ticks_i     (cfg.hold_ticks[b]),
      .repeat_ticks_i   (cfg.repeat_ticks),
      .event_o          (lane_ev[b])
    );
  end

  bchr_merge #(
    .LANES (Lanes)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .lane_ev_i   (lane_ev),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/button_click_hold_repeat_tb.sv =====
// ----------------------------------------------------------------------------
// button_click_hold_repeat_tb: self-checking bench for the button event block
// Streams tick beats of raw button levels under random sender gaps and
// receiver stalls, predicts click / hold / repeat events per button lane, and
// compares every result beat in order across several register settings.
// ----------------------------------------------------------------------------
module button_click_hold_repeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bchr_pkg::CfgIdxW-1:0]  CfgSpare    = 3'd7;
  localparam logic [bchr_pkg::RegWidth-1:0] CountTop    = 16'hFFFF;
  localparam int                            CycleLimit  = 100_000;
  localparam int                            ReportLimit = 10;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  bchr_pkg::in_t                 in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  bchr_pkg::out_t                out_data_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [bchr_pkg::CfgIdxW-1:0]  cfg_index_i = bchr_pkg::CfgDebounce;
  logic [bchr_pkg::RegWidth-1:0] cfg_data_i  = '0;

  button_click_hold_repeat uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Button lane mirror and register copy
  logic [bchr_pkg::RegWidth-1:0]   debounce_lim;
  logic [bchr_pkg::RegWidth-1:0]   hold_lim [bchr_pkg::NumButtons];
  logic [bchr_pkg::RegWidth-1:0]   repeat_lim;
  logic                            press_level;
  logic                            lane_pressed [bchr_pkg::NumButtons];
  logic [bchr_pkg::CountWidth-1:0] lane_debounce [bchr_pkg::NumButtons];
  logic [bchr_pkg::CountWidth-1:0] lane_hold [bchr_pkg::NumButtons];
  logic                            lane_fired [bchr_pkg::NumButtons];

  bchr_pkg::out_t pending_events[$];

  int unsigned cycle_count;
  int unsigned beats_checked;
  int unsigned mismatch_count;
  int unsigned unexpected_count;
  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned clicks_seen;
  int unsigned holds_seen;
  int unsigned repeats_seen;
  int          burst_left;

  // Random-walk state of the button stimulus, in pressed terms
  logic intent_pressed [bchr_pkg::NumButtons];
  int   intent_dwell [bchr_pkg::NumButtons];

  function automatic logic [bchr_pkg::CountWidth-1:0] sat_inc(
      input logic [bchr_pkg::CountWidth-1:0] c);
    return (c == {bchr_pkg::CountWidth{1'b1}}) ? c : c + bchr_pkg::CountWidth'(1);
  endfunction

  function automatic void reset_lanes();
    debounce_lim = bchr_pkg::DebounceReset;
    repeat_lim   = bchr_pkg::RepeatReset;
    press_level  = 1'b0;
    for (int b = 0; b < bchr_pkg::NumButtons; b++) begin
      hold_lim[b]      = bchr_pkg::HoldReset;
      lane_pressed[b]  = 1'b0;
      lane_debounce[b] = '0;
      lane_hold[b]     = '0;
      lane_fired[b]    = 1'b0;
    end
  endfunction

  function automatic void apply_reg(input logic [bchr_pkg::CfgIdxW-1:0] idx,
                                    input logic [bchr_pkg::RegWidth-1:0] data);
    case (idx)
      bchr_pkg::CfgDebounce:  debounce_lim = data;
      bchr_pkg::CfgHoldEnter: hold_lim[bchr_pkg::BtnEnter] = data;
      bchr_pkg::CfgHoldUp:    hold_lim[bchr_pkg::BtnUp] = data;
      bchr_pkg::CfgHoldDown:  hold_lim[bchr_pkg::BtnDown] = data;
      bchr_pkg::CfgHoldExit:  hold_lim[bchr_pkg::BtnExit] = data;
      bchr_pkg::CfgRepeat:    repeat_lim = data;
      bchr_pkg::CfgPressed:   press_level = data[0];
      default: ;
    endcase
  endfunction

  function automatic bchr_pkg::event_e lane_event(input int b, input logic raw_pressed);
    bchr_pkg::event_e ev;
    ev = bchr_pkg::EvNone;
    if (raw_pressed == lane_pressed[b]) begin
      lane_debounce[b] = '0;
    end else begin
      lane_debounce[b] = sat_inc(lane_debounce[b]);
      if (lane_debounce[b] >= debounce_lim) begin
        lane_debounce[b] = '0;
        lane_pressed[b]  = raw_pressed;
        if (!raw_pressed && !lane_fired[b]) ev = bchr_pkg::EvClick;
        lane_hold[b]  = '0;
        lane_fired[b] = 1'b0;
        return ev;
      end
    end
    if (lane_pressed[b]) begin
      lane_hold[b] = sat_inc(lane_hold[b]);
      if (!lane_fired[b]) begin
        if (lane_hold[b] >= hold_lim[b]) begin
          ev            = bchr_pkg::EvHoldOnce;
          lane_fired[b] = 1'b1;
          lane_hold[b]  = '0;
        end
      end else if (lane_hold[b] >= repeat_lim) begin
        ev           = bchr_pkg::EvHoldRepeat;
        lane_hold[b] = '0;
      end
    end
    return ev;
  endfunction

  function automatic bchr_pkg::out_t predict_events(input bchr_pkg::in_t t);
    logic             raw [bchr_pkg::NumButtons];
    bchr_pkg::event_e ev [bchr_pkg::NumButtons];
    bchr_pkg::out_t   r;
    raw[bchr_pkg::BtnEnter] = t.raw_enter;
    raw[bchr_pkg::BtnUp]    = t.raw_up;
    raw[bchr_pkg::BtnDown]  = t.raw_down;
    raw[bchr_pkg::BtnExit]  = t.raw_exit;
    for (int b = 0; b < bchr_pkg::NumButtons; b++) begin
      ev[b] = lane_event(b, raw[b] == press_level);
      case (ev[b])
        bchr_pkg::EvClick:      clicks_seen++;
        bchr_pkg::EvHoldOnce:   holds_seen++;
        bchr_pkg::EvHoldRepeat: repeats_seen++;
        default: ;
      endcase
    end
    r.event_enter = ev[bchr_pkg::BtnEnter];
    r.event_up    = ev[bchr_pkg::BtnUp];
    r.event_down  = ev[bchr_pkg::BtnDown];
    r.event_exit  = ev[bchr_pkg::BtnExit];
    return r;
  endfunction

  // Receiver: check each accepted beat, stall on a rotating pattern
  always @(posedge clk_i) begin
    bchr_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_checked++;
      if (pending_events.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= ReportLimit)
          $display("beat %0d: result with nothing expected", beats_checked);
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.event_enter !== want.event_enter ||
            out_data_o.event_up    !== want.event_up ||
            out_data_o.event_down  !== want.event_down ||
            out_data_o.event_exit  !== want.event_exit) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= ReportLimit)
            $display({"beat %0d: enter/up/down/exit expected %0d/%0d/%0d/%0d",
                      " got %0d/%0d/%0d/%0d"},
                     beats_checked, want.event_enter, want.event_up, want.event_down,
                     want.event_exit, out_data_o.event_enter, out_data_o.event_up,
                     out_data_o.event_down, out_data_o.event_exit);
        end
      end
    end
    case (cycle_count[9:8])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 1) != 0);
      2'd2: out_ready_i <= (cycle_count[1:0] == 2'd0);
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_tick(input bchr_pkg::in_t t);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    ticks_sent++;
    pending_events.push_back(predict_events(t));
  endtask

  task automatic send_levels(input logic [bchr_pkg::NumFields-1:0] levels);
    bchr_pkg::in_t t;
    t = bchr_pkg::in_t'(levels);
    send_tick(t);
  endtask

  // Hold until every expected beat has drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bchr_pkg::CfgIdxW-1:0] idx,
                           input logic [bchr_pkg::RegWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic set_config(input logic [bchr_pkg::RegWidth-1:0] deb,
                            input logic [bchr_pkg::RegWidth-1:0] h_enter,
                            input logic [bchr_pkg::RegWidth-1:0] h_up,
                            input logic [bchr_pkg::RegWidth-1:0] h_down,
                            input logic [bchr_pkg::RegWidth-1:0] h_exit,
                            input logic [bchr_pkg::RegWidth-1:0] rep,
                            input logic [bchr_pkg::RegWidth-1:0] lvl);
    write_reg(bchr_pkg::CfgDebounce, deb);
    write_reg(bchr_pkg::CfgHoldEnter, h_enter);
    write_reg(bchr_pkg::CfgHoldUp, h_up);
    write_reg(bchr_pkg::CfgHoldDown, h_down);
    write_reg(bchr_pkg::CfgHoldExit, h_exit);
    write_reg(bchr_pkg::CfgRepeat, rep);
    write_reg(bchr_pkg::CfgPressed, lvl);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly clean press/release runs with random dwell, some bounce and noise
  task automatic run_presses(input int n, input int dwell_max);
    logic [bchr_pkg::NumFields-1:0] levels;
    logic                           lvl;
    for (int i = 0; i < n; i++) begin
      for (int b = 0; b < bchr_pkg::NumButtons; b++) begin
        if (intent_dwell[b] <= 0) begin
          intent_pressed[b] = ~intent_pressed[b];
          intent_dwell[b]   = $urandom_range(1, dwell_max);
        end
        intent_dwell[b]--;
        lvl = intent_pressed[b] ? press_level : ~press_level;
        if ($urandom_range(0, 9) == 0) lvl = ~lvl;
        levels[bchr_pkg::NumFields-1-b] = lvl;
      end
      if ($urandom_range(0, 15) == 0)
        levels = bchr_pkg::NumFields'($urandom_range(0, 15));
      send_levels(levels);
    end
  endtask

  task automatic test_reset_defaults();
    run_presses(80, 60);
    wait_idle();
  endtask

  task automatic test_directed();
    logic [bchr_pkg::NumFields-1:0] seq [19] = '{
      4'b0000, 4'b1111, 4'b1111, 4'b1111, 4'b1111, 4'b1111, 4'b1111,
      4'b0110, 4'b0000, 4'b1010, 4'b0101, 4'b1010, 4'b0101, 4'b1111,
      4'b1111, 4'b0000, 4'b0000, 4'b1000, 4'b0000
    };
    // Pressed level goes high through the masked bit; the spare index is ignored
    write_reg(bchr_pkg::CfgPressed, 16'hFFFF);
    write_reg(CfgSpare, 16'h0003);
    write_reg(bchr_pkg::CfgDebounce, 16'd1);
    write_reg(bchr_pkg::CfgHoldEnter, 16'd2);
    write_reg(bchr_pkg::CfgHoldUp, 16'd3);
    write_reg(bchr_pkg::CfgHoldDown, 16'd1);
    write_reg(bchr_pkg::CfgHoldExit, 16'd4);
    write_reg(bchr_pkg::CfgRepeat, 16'd1);
    cfg_valid_i <= 1'b0;
    settings_used++;
    foreach (seq[i]) send_levels(seq[i]);
    wait_idle();
  endtask

  task automatic test_zero_settings();
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0001);
    run_presses(50, 6);
    wait_idle();
  endtask

  // Enter held past a long first-hold threshold, then released with no click
  task automatic test_long_hold();
    logic [bchr_pkg::NumFields-1:0] released;
    logic [bchr_pkg::NumFields-1:0] enter_down;
    set_config(16'd0, 16'd40, 16'd2, 16'd2, 16'd2, 16'd3, 16'hFFFE);
    released   = {bchr_pkg::NumFields{~press_level}};
    enter_down = released;
    enter_down[bchr_pkg::NumFields-1-bchr_pkg::BtnEnter] = press_level;
    for (int i = 0; i < 48; i++) send_levels(enter_down);
    send_levels(released);
    send_levels(released);
    wait_idle();
  endtask

  task automatic test_random_settings();
    set_config(16'd1, 16'd3, 16'd5, 16'd2, 16'd7, 16'd2, 16'd0);
    run_presses(80, 16);
    wait_idle();
    set_config(16'd2, 16'd1, 16'd4, 16'd6, 16'd10, 16'd3, 16'd1);
    run_presses(80, 20);
    wait_idle();
    set_config(CountTop, CountTop, CountTop, CountTop, CountTop, CountTop, 16'd0);
    run_presses(30, 8);
    wait_idle();
    set_config(bchr_pkg::RegWidth'($urandom_range(0, 3)),
               bchr_pkg::RegWidth'($urandom_range(1, 12)),
               bchr_pkg::RegWidth'($urandom_range(1, 12)),
               bchr_pkg::RegWidth'($urandom_range(1, 12)),
               bchr_pkg::RegWidth'($urandom_range(1, 12)),
               bchr_pkg::RegWidth'($urandom_range(1, 6)),
               bchr_pkg::RegWidth'($urandom_range(0, 16'hFFFF)));
    run_presses(80, 24);
    wait_idle();
  endtask

  initial begin
    int unsigned failures;
    reset_lanes();
    burst_left = 0;
    for (int b = 0; b < bchr_pkg::NumButtons; b++) begin
      intent_pressed[b] = 1'b0;
      intent_dwell[b]   = $urandom_range(1, 10);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed();
    test_zero_settings();
    test_random_settings();
    test_long_hold();

    wait_idle();
    repeat (4) @(posedge clk_i);
    failures = mismatch_count + unexpected_count + pending_events.size();
    $display("Ran %0d tick beats over %0d register settings plus reset defaults, %0d checked",
             ticks_sent, settings_used, beats_checked);
    $display("Events predicted: %0d clicks, %0d first holds, %0d repeats; %0d failures",
             clicks_seen, holds_seen, repeats_seen, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bchr_pkg.sv
rtl/core/bchr_cfg.sv
rtl/core/bchr_lane.sv
rtl/core/bchr_merge.sv
rtl/core/button_click_hold_repeat.sv
sim/button_click_hold_repeat_tb.sv
